>>> design/tcqd_pkg.sv
// ----------------------------------------------------------------------------
// tcqd_pkg: shared types and constants for the three-channel quadrature decoder
// beat layouts, opcodes, register map, delta table and saturation helpers
// ----------------------------------------------------------------------------
package tcqd_pkg;

  localparam int ACCUM_WIDTH = 32;
  localparam int PADDR_WIDTH = 4;

  typedef enum logic [2:0] {
    OP_SAMPLE     = 3'd0,
    OP_READ_LEFT  = 3'd1,
    OP_READ_RIGHT = 3'd2,
    OP_LOAD_STEP  = 3'd3,
    OP_INIT       = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    REG_LEFT_REVERSE    = 2'd0,
    REG_RIGHT_REVERSE   = 2'd1,
    REG_STEPPER_REVERSE = 2'd2
  } reg_index_t;

  typedef logic signed [ACCUM_WIDTH-1:0] accum_t;

  typedef struct packed {
    logic [2:0]         opcode;
    logic               left_a;
    logic               left_b;
    logic               right_a;
    logic               right_b;
    logic               stepper_a;
    logic               stepper_b;
    logic signed [31:0] new_stepper_count;
  } sample_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic signed [31:0] stepper_position;
    logic [31:0]        illegal_transitions;
  } result_t;

  // indexed by {prev, next}
  localparam logic signed [1:0] STEP_TABLE [16] = '{
     2'sd0, -2'sd1,  2'sd1,  2'sd0,
     2'sd1,  2'sd0,  2'sd0, -2'sd1,
    -2'sd1,  2'sd0,  2'sd0,  2'sd1,
     2'sd0,  2'sd1, -2'sd1,  2'sd0
  };

  localparam accum_t SAT_MAX = accum_t'(32767);
  localparam accum_t SAT_MIN = -SAT_MAX - accum_t'(1);

  function automatic accum_t apply_delta(accum_t acc, logic [1:0] prev, logic [1:0] next,
                                         logic rev);
    logic signed [1:0] d;
    d = STEP_TABLE[{prev, next}];
    if (rev) begin
      d = -d;
    end
    return acc + accum_t'(d);
  endfunction

  function automatic logic signed [15:0] saturate16(accum_t acc);
    logic signed [15:0] r;
    if (acc < SAT_MIN) begin
      r = 16'sh8000;
    end else if (acc > SAT_MAX) begin
      r = 16'sh7fff;
    end else begin
      r = acc[15:0];
    end
    return r;
  endfunction

endpackage

>>> design/three_channel_quadrature_decoder.sv
// pipeline: an accepted sample beat passes through the input register, then the result register
// throughput: one beat per cycle; the input register refills while the result
// register drains, so only a stalled result register holds off new beats
// reset: synchronous active-high rst clears counters, pin history and the valid
// flags; left_reverse resets to 1, the other reverse bits to 0
// ----------------------------------------------------------------------------
// three_channel_quadrature_decoder
// x4 decode of left wheel, right wheel and stepper encoders with apb config
// ----------------------------------------------------------------------------
module three_channel_quadrature_decoder
  import tcqd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic    left_reverse;
  logic    right_reverse;
  logic    stepper_reverse;

  logic    item_valid;
  sample_t item;

  logic [1:0] left_prev, right_prev, stepper_prev;
  accum_t     left_accum, right_accum, stepper_accum;
  logic [31:0] error_tally;

  logic [1:0] left_prev_next, right_prev_next, stepper_prev_next;
  accum_t     left_accum_next, right_accum_next, stepper_accum_next;
  logic [31:0] error_tally_next;
  logic signed [15:0] read_value_next;
  logic [1:0] ln, rn, sn;

  logic proc;
  logic cfg_write;
  reg_index_t cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_comb begin
    case (cfg_index)
      REG_LEFT_REVERSE:    prdata = 32'(left_reverse);
      REG_RIGHT_REVERSE:   prdata = 32'(right_reverse);
      REG_STEPPER_REVERSE: prdata = 32'(stepper_reverse);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_reverse    <= 1'b1;
      right_reverse   <= 1'b0;
      stepper_reverse <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LEFT_REVERSE:    left_reverse    <= pwdata[0];
        REG_RIGHT_REVERSE:   right_reverse   <= pwdata[0];
        REG_STEPPER_REVERSE: stepper_reverse <= pwdata[0];
        default: ;
      endcase
    end
  end

  // input register advances whenever the result register can take a beat
  assign proc         = item_valid && (!result_valid || result_ready);
  assign sample_ready = !item_valid || proc;

  assign ln = {item.left_a, item.left_b};
  assign rn = {item.right_a, item.right_b};
  assign sn = {item.stepper_a, item.stepper_b};

  always_comb begin
    left_prev_next     = left_prev;
    right_prev_next    = right_prev;
    stepper_prev_next  = stepper_prev;
    left_accum_next    = left_accum;
    right_accum_next   = right_accum;
    stepper_accum_next = stepper_accum;
    error_tally_next   = error_tally;
    read_value_next    = '0;
    case (item.opcode)
      OP_SAMPLE: begin
        left_accum_next   = apply_delta(left_accum, left_prev, ln, left_reverse);
        right_accum_next  = apply_delta(right_accum, right_prev, rn, right_reverse);
        left_prev_next    = ln;
        right_prev_next   = rn;
        stepper_prev_next = sn;
        if ((stepper_prev ^ sn) == 2'b11) begin
          error_tally_next = error_tally + 32'd1;
        end else begin
          stepper_accum_next = apply_delta(stepper_accum, stepper_prev, sn, stepper_reverse);
        end
      end
      OP_READ_LEFT: begin
        read_value_next = saturate16(left_accum);
        left_accum_next = '0;
      end
      OP_READ_RIGHT: begin
        read_value_next  = saturate16(right_accum);
        right_accum_next = '0;
      end
      OP_LOAD_STEP: begin
        stepper_accum_next = accum_t'(item.new_stepper_count);
      end
      OP_INIT: begin
        left_prev_next     = ln;
        right_prev_next    = rn;
        stepper_prev_next  = sn;
        left_accum_next    = '0;
        right_accum_next   = '0;
        stepper_accum_next = '0;
        error_tally_next   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid    <= 1'b0;
      result_valid  <= 1'b0;
      left_prev     <= '0;
      right_prev    <= '0;
      stepper_prev  <= '0;
      left_accum    <= '0;
      right_accum   <= '0;
      stepper_accum <= '0;
      error_tally   <= '0;
    end else begin
      if (sample_ready) begin
        item_valid <= sample_valid;
      end
      if (proc) begin
        result_valid  <= 1'b1;
        left_prev     <= left_prev_next;
        right_prev    <= right_prev_next;
        stepper_prev  <= stepper_prev_next;
        left_accum    <= left_accum_next;
        right_accum   <= right_accum_next;
        stepper_accum <= stepper_accum_next;
        error_tally   <= error_tally_next;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (sample_ready && sample_valid) begin
      item <= sample;
    end
    if (proc) begin
      result.read_value          <= read_value_next;
      result.stepper_position    <= 32'(stepper_accum_next);
      result.illegal_transitions <= error_tally_next;
    end
  end

`ifndef SYNTHESIS
  a_item_held: assert property (@(posedge clk) disable iff (rst)
    item_valid && !proc |=> item_valid)
    else $error("pending item dropped while result stalled");

  a_init_clears: assert property (@(posedge clk) disable iff (rst)
    proc && item.opcode == OP_INIT |=>
      result.illegal_transitions == 32'd0 && left_accum == '0 && right_accum == '0)
    else $error("init did not clear counters");

  a_read_clears: assert property (@(posedge clk) disable iff (rst)
    proc && item.opcode == OP_READ_LEFT |=> left_accum == '0)
    else $error("left read did not clear accumulator");

  a_tally_step: assert property (@(posedge clk) disable iff (rst)
    proc |=> error_tally == $past(error_tally) ||
             error_tally == $past(error_tally) + 32'd1 || error_tally == 32'd0)
    else $error("error tally moved by more than one");

  a_result_tally: assert property (@(posedge clk) disable iff (rst)
    proc |=> result.illegal_transitions == error_tally)
    else $error("result tally differs from state");
`endif

endmodule

>>> dv/three_channel_quadrature_decoder_tb.sv
// ----------------------------------------------------------------------------
// three_channel_quadrature_decoder_tb
// self-checking bench: sample beats drive an in-bench decoder model, every
// result beat is compared field by field, reverse bits change between phases
// ----------------------------------------------------------------------------
module three_channel_quadrature_decoder_tb;
  import tcqd_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int RESET_CYCLES = 11;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int DRAIN_LIMIT = 20_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEGMENT_BEATS = 185;
  localparam int RUN_SPAN = 30;
  localparam int PRINT_LIMIT = 100;
  localparam int COUNT_MAX = 32767;
  localparam int COUNT_MIN = -32768;
  localparam logic [2:0] FIRST_UNUSED_OP = 3'd5;
  localparam logic [2:0] LAST_UNUSED_OP = 3'd7;
  localparam logic [1:0] BOTH_PINS = 2'b11;
  localparam logic [1:0] PIN_A = 2'b10;
  localparam logic [1:0] PIN_B = 2'b01;
  localparam logic [1:0] GRAY_CYCLE [4] = '{2'b00, 2'b01, 2'b11, 2'b10};
  localparam int QUAD_DELTA [16] = '{
     0, -1,  1,  0,
     1,  0,  0, -1,
    -1,  0,  0,  1,
     0,  1, -1,  0
  };
  localparam logic [31:0] COUNT_EXTREMES [4] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff
  };

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   sample_valid;
  logic                   sample_ready;
  sample_t                sample_beat;
  logic                   result_valid;
  logic                   result_ready;
  result_t                result_beat;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  // decoder model state
  logic               left_rev = 1'b1;
  logic               right_rev = 1'b0;
  logic               step_rev = 1'b0;
  logic [1:0]         left_phase = '0;
  logic [1:0]         right_phase = '0;
  logic [1:0]         step_phase = '0;
  logic signed [31:0] left_count = '0;
  logic signed [31:0] right_count = '0;
  logic signed [31:0] step_pos = '0;
  logic [31:0]        illegal_count = '0;

  result_t pending_results [$];
  int      mismatch_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;

  three_channel_quadrature_decoder DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) begin
      $display("mismatch at %0t: %s", $time, what);
    end
  endtask

  function automatic logic [31:0] step_count(logic [31:0] acc, logic [1:0] prev,
                                             logic [1:0] next, logic rev);
    int d;
    d = QUAD_DELTA[{prev, next}];
    if (rev) begin
      d = -d;
    end
    return acc + 32'(d);
  endfunction

  function automatic logic signed [15:0] clamp_count(logic signed [31:0] v);
    if (v > COUNT_MAX) begin
      return 16'(COUNT_MAX);
    end
    if (v < COUNT_MIN) begin
      return 16'(COUNT_MIN);
    end
    return v[15:0];
  endfunction

  function automatic result_t decode_sample(sample_t s);
    result_t    r;
    logic [1:0] ln;
    logic [1:0] rn;
    logic [1:0] sn;
    ln = {s.left_a, s.left_b};
    rn = {s.right_a, s.right_b};
    sn = {s.stepper_a, s.stepper_b};
    r.read_value = '0;
    case (s.opcode)
      OP_SAMPLE: begin
        left_count = step_count(left_count, left_phase, ln, left_rev);
        left_phase = ln;
        right_count = step_count(right_count, right_phase, rn, right_rev);
        right_phase = rn;
        if ((step_phase ^ sn) == BOTH_PINS) begin
          illegal_count = illegal_count + 32'd1;
        end else begin
          step_pos = step_count(step_pos, step_phase, sn, step_rev);
        end
        step_phase = sn;
      end
      OP_READ_LEFT: begin
        r.read_value = clamp_count(left_count);
        left_count = '0;
      end
      OP_READ_RIGHT: begin
        r.read_value = clamp_count(right_count);
        right_count = '0;
      end
      OP_LOAD_STEP: begin
        step_pos = s.new_stepper_count;
      end
      OP_INIT: begin
        left_phase = ln;
        right_phase = rn;
        step_phase = sn;
        left_count = '0;
        right_count = '0;
        step_pos = '0;
        illegal_count = '0;
      end
      default: begin
      end
    endcase
    r.stepper_position = step_pos;
    r.illegal_transitions = illegal_count;
    return r;
  endfunction

  function automatic sample_t pin_beat(logic [2:0] op, logic [1:0] l, logic [1:0] r,
                                       logic [1:0] st, logic [31:0] cnt);
    sample_t s;
    s.opcode = op;
    {s.left_a, s.left_b} = l;
    {s.right_a, s.right_b} = r;
    {s.stepper_a, s.stepper_b} = st;
    s.new_stepper_count = cnt;
    return s;
  endfunction

  // mostly single-pin moves, some holds, a few double moves
  function automatic logic [1:0] random_move();
    int m;
    m = $urandom_range(19);
    if (m < 4) begin
      return '0;
    end
    if (m < 11) begin
      return PIN_B;
    end
    if (m < 18) begin
      return PIN_A;
    end
    return BOTH_PINS;
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      pick;
    {s.left_a, s.left_b, s.right_a, s.right_b, s.stepper_a, s.stepper_b} = 6'($urandom);
    s.new_stepper_count = $urandom;
    if ($urandom_range(99) < 8) begin
      s.new_stepper_count = COUNT_EXTREMES[$urandom_range(3)];
    end
    pick = $urandom_range(99);
    if (pick < 68) begin
      s.opcode = OP_SAMPLE;
      // a few beats keep fully random pins as noise
      if ($urandom_range(19) != 0) begin
        {s.left_a, s.left_b} = left_phase ^ random_move();
        {s.right_a, s.right_b} = right_phase ^ random_move();
        {s.stepper_a, s.stepper_b} = step_phase ^ random_move();
      end
    end else if (pick < 76) begin
      s.opcode = OP_READ_LEFT;
    end else if (pick < 84) begin
      s.opcode = OP_READ_RIGHT;
    end else if (pick < 90) begin
      s.opcode = OP_LOAD_STEP;
    end else if (pick < 95) begin
      s.opcode = OP_INIT;
    end else begin
      s.opcode = FIRST_UNUSED_OP + 3'($urandom_range(LAST_UNUSED_OP - FIRST_UNUSED_OP));
    end
    return s;
  endfunction

  task automatic send_sample(input sample_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample_beat <= beat;
    @(posedge clk);
    while (!sample_ready) begin
      @(posedge clk);
    end
    pending_results.push_back(decode_sample(beat));
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    sample_valid <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_mismatch($sformatf("%0d result beats never arrived", pending_results.size()));
      pending_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_WIDTH'({idx, 2'b00});
    pwdata <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LEFT_REVERSE:    left_rev = val;
      REG_RIGHT_REVERSE:   right_rev = val;
      REG_STEPPER_REVERSE: step_rev = val;
      default: begin
      end
    endcase
  endtask

  task automatic check_reg(input reg_index_t idx, input logic want);
    logic [31:0] data;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= PADDR_WIDTH'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    data = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (data !== 32'(want)) begin
      report_mismatch($sformatf("register %s read %0h expected %0h", idx.name(), data, want));
    end
  endtask

  task automatic set_reverse(input logic l, input logic r, input logic st);
    drain_results();
    write_reg(REG_LEFT_REVERSE, l);
    write_reg(REG_RIGHT_REVERSE, r);
    write_reg(REG_STEPPER_REVERSE, st);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with no sample beat pending");
      end else begin
        want = pending_results.pop_front();
        if (result_beat.read_value !== want.read_value) begin
          report_mismatch($sformatf("read_value got %0d expected %0d",
                                    result_beat.read_value, want.read_value));
        end
        if (result_beat.stepper_position !== want.stepper_position) begin
          report_mismatch($sformatf("stepper_position got %0h expected %0h",
                                    result_beat.stepper_position, want.stepper_position));
        end
        if (result_beat.illegal_transitions !== want.illegal_transitions) begin
          report_mismatch($sformatf("illegal_transitions got %0d expected %0d",
                                    result_beat.illegal_transitions,
                                    want.illegal_transitions));
        end
      end
    end
  end

  task automatic test_register_access();
    check_reg(REG_LEFT_REVERSE, 1'b1);
    check_reg(REG_RIGHT_REVERSE, 1'b0);
    check_reg(REG_STEPPER_REVERSE, 1'b0);
    write_reg(REG_LEFT_REVERSE, 1'b0);
    write_reg(REG_RIGHT_REVERSE, 1'b1);
    write_reg(REG_STEPPER_REVERSE, 1'b1);
    check_reg(REG_LEFT_REVERSE, 1'b0);
    check_reg(REG_RIGHT_REVERSE, 1'b1);
    check_reg(REG_STEPPER_REVERSE, 1'b1);
    write_reg(REG_LEFT_REVERSE, 1'b1);
    write_reg(REG_RIGHT_REVERSE, 1'b0);
    write_reg(REG_STEPPER_REVERSE, 1'b0);
    check_reg(REG_LEFT_REVERSE, 1'b1);
    check_reg(REG_RIGHT_REVERSE, 1'b0);
    check_reg(REG_STEPPER_REVERSE, 1'b0);
  endtask

  task automatic test_directed_patterns();
    send_idle_pct = 37;
    recv_idle_pct = 49;
    send_sample(pin_beat(OP_INIT, 2'b00, 2'b00, 2'b00, '0));
    // one full turn on every channel
    for (int i = 1; i <= 4; i++) begin
      send_sample(pin_beat(OP_SAMPLE, GRAY_CYCLE[i % 4], GRAY_CYCLE[i % 4],
                           GRAY_CYCLE[i % 4], $urandom));
    end
    // pins unchanged
    send_sample(pin_beat(OP_SAMPLE, 2'b00, 2'b00, 2'b00, '0));
    // both pins flip at once
    send_sample(pin_beat(OP_SAMPLE, BOTH_PINS, BOTH_PINS, BOTH_PINS, '1));
    send_sample(pin_beat(OP_SAMPLE, 2'b00, 2'b00, 2'b00, '0));
    send_sample(pin_beat(OP_READ_LEFT, BOTH_PINS, BOTH_PINS, BOTH_PINS, '0));
    send_sample(pin_beat(OP_READ_RIGHT, BOTH_PINS, BOTH_PINS, BOTH_PINS, '0));
    // stepper load and wrap at both ends
    send_sample(pin_beat(OP_LOAD_STEP, 2'b00, 2'b00, 2'b00, COUNT_EXTREMES[0]));
    send_sample(pin_beat(OP_SAMPLE, 2'b00, 2'b00, PIN_A, '0));
    send_sample(pin_beat(OP_LOAD_STEP, 2'b00, 2'b00, 2'b00, COUNT_EXTREMES[1]));
    send_sample(pin_beat(OP_SAMPLE, 2'b00, 2'b00, 2'b00, '0));
    send_sample(pin_beat(OP_LOAD_STEP, BOTH_PINS, BOTH_PINS, BOTH_PINS, COUNT_EXTREMES[2]));
    send_sample(pin_beat(OP_LOAD_STEP, 2'b00, 2'b00, 2'b00, COUNT_EXTREMES[3]));
    for (int op = FIRST_UNUSED_OP; op <= LAST_UNUSED_OP; op++) begin
      send_sample(pin_beat(3'(op), 2'($urandom), 2'($urandom), 2'($urandom), $urandom));
    end
    send_sample(pin_beat(OP_INIT, BOTH_PINS, BOTH_PINS, BOTH_PINS, '1));
    send_sample(pin_beat(OP_SAMPLE, 2'b00, 2'b00, 2'b00, '1));
    send_sample(pin_beat(OP_READ_LEFT, 2'b00, 2'b00, 2'b00, '0));
    send_sample(pin_beat(OP_READ_RIGHT, 2'b00, 2'b00, 2'b00, '0));
  endtask

  // left counts up and right counts down over runs of growing length, then both are read
  task automatic test_count_runs();
    int span;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_reverse(1'b1, 1'b0, 1'($urandom_range(1)));
    for (int k = 0; k < 3; k++) begin
      span = RUN_SPAN + k;
      send_sample(pin_beat(OP_INIT, 2'b00, 2'b00, 2'b00, $urandom));
      for (int i = 1; i <= span; i++) begin
        send_sample(pin_beat(OP_SAMPLE, GRAY_CYCLE[i % 4], GRAY_CYCLE[i % 4],
                             GRAY_CYCLE[i % 4], $urandom));
      end
      send_sample(pin_beat(OP_READ_LEFT, 2'($urandom), 2'($urandom), 2'($urandom), $urandom));
      send_sample(pin_beat(OP_READ_RIGHT, 2'($urandom), 2'($urandom), 2'($urandom), $urandom));
    end
  endtask

  task automatic run_segment(input logic l, input logic r, input logic st);
    set_reverse(l, r, st);
    repeat (SEGMENT_BEATS) send_sample(random_sample());
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 37;
    recv_idle_pct = 49;
    run_segment(1'b0, 1'b0, 1'b0);
    run_segment(1'($urandom), 1'($urandom), 1'($urandom));
    send_idle_pct = 49;
    recv_idle_pct = 37;
    run_segment(1'b1, 1'b1, 1'b1);
    run_segment(1'($urandom), 1'($urandom), 1'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_segment(1'b1, 1'b0, 1'b1);
    run_segment(1'($urandom), 1'($urandom), 1'($urandom));
  endtask

  initial begin
    rst <= 1'b1;
    sample_valid <= 1'b0;
    sample_beat <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_directed_patterns();
    test_count_runs();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("TEST FAILED");
    $finish;
  end

endmodule
